### sv/satlb_pkg.sv
// shared types, constants and command/status structs for the tlb
`timescale 1ns / 1ps

package satlb_pkg;

  // default geometry
  localparam int unsigned SETS_DEF      = 16;
  localparam int unsigned WAYS_DEF      = 4;
  localparam int unsigned PAGE_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned RANK_OUT_W = 3;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 72;

  // item kinds carried on the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_XLATE = 2'd0,
    FUNC_PEEK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_MOD   = 3'd2,
    ST_LOOK  = 3'd3,
    ST_DONE  = 3'd4
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic rd_en;
    logic look_en;
    logic resp_en;
    logic clr_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;
    logic is_clear;
    logic clr_last;
    logic out_busy;
  } status_t;

endpackage

### sv/satlb_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module satlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/satlb_ctrl.sv
// sequencing state machine for the tlb
`timescale 1ns / 1ps

module satlb_ctrl import satlb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register, reset starts with the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_MOD;
      ST_MOD:   if (status_i.mod_done) state_d = ST_LOOK;
      ST_LOOK:  state_d = ST_DONE;
      ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = status_i.is_clear ? ST_CLEAR : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_MOD:   cmd_o.rd_en = status_i.mod_done;
      ST_LOOK:  cmd_o.look_en = 1'b1;
      ST_DONE:  cmd_o.resp_en = !status_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end

`ifndef SYNTHESIS
  // an accepted transaction always moves on to set index computation
  a_accept_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> state_q == ST_MOD)
    else $error("accepted transaction did not enter set index phase");
`endif

endmodule

### sv/satlb_dp.sv
// tlb datapath: set index unit, set row lookup and update, result register
`timescale 1ns / 1ps

module satlb_dp import satlb_pkg::*; #(
  parameter int unsigned SETS      = SETS_DEF,
  parameter int unsigned WAYS      = WAYS_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [FUNC_W-1:0]     in_func_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned PW        = ADDR_W - PAGE_BITS;
  localparam int unsigned RANK_W    = $clog2(WAYS + 1);
  localparam int unsigned WAY_W     = 1 + 2 * PW + RANK_W;
  localparam int unsigned ROW_W     = WAYS * WAY_W;
  localparam int unsigned IDX_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WIDX_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit          SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam int unsigned MOD_STEPS = (PW + 3) / 4;
  localparam int unsigned MOD_W     = MOD_STEPS * 4;
  localparam int unsigned CNT_W     = $clog2(MOD_STEPS + 1);

  // latched item
  func_e                func_q;
  logic [PW-1:0]        page_q;
  logic [PAGE_BITS-1:0] off_q;
  logic [PW-1:0]        walk_frame_q;
  logic                 walk_fault_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q       <= func_e'(in_func_i);
      page_q       <= in_data_i[ADDR_W-1:PAGE_BITS];
      off_q        <= in_data_i[PAGE_BITS-1:0];
      walk_frame_q <= in_data_i[2*ADDR_W-1:ADDR_W+PAGE_BITS];
      walk_fault_q <= in_data_i[2*ADDR_W];
    end
  end

  // set index: page modulo set count, four quotient bits per cycle
  logic [MOD_W-1:0] mod_sh_q;
  logic [CNT_W-1:0] mod_cnt_q;
  logic [IDX_W-1:0] set_q, set_step;

  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    r = set_q;
    for (int i = 0; i < 4; i++) begin
      t = {r, mod_sh_q[MOD_W-1-i]};
      if (t >= (IDX_W+1)'(SETS)) begin
        t = t - (IDX_W+1)'(SETS);
      end
      r = t[IDX_W-1:0];
    end
    set_step = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_cnt_q <= '0;
    end else if (cmd_i.load_item) begin
      mod_cnt_q <= SETS_POW2 ? '0 : CNT_W'(MOD_STEPS);
    end else if (mod_cnt_q != '0) begin
      mod_cnt_q <= mod_cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mod_sh_q <= MOD_W'(in_data_i[ADDR_W-1:PAGE_BITS]);
      if (!SETS_POW2 || SETS == 1) begin
        set_q <= '0;
      end else begin
        set_q <= in_data_i[PAGE_BITS +: IDX_W];
      end
    end else if (mod_cnt_q != '0) begin
      mod_sh_q <= mod_sh_q << 4;
      set_q    <= set_step;
    end
  end

  // clearing sweep counter, wraps to zero after the last set
  logic [IDX_W-1:0] clr_cnt_q;
  logic             clr_last;

  assign clr_last = (clr_cnt_q == IDX_W'(SETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + IDX_W'(1);
    end
  end

  // set row storage
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  logic [ROW_W-1:0] row_q;
  logic             wr_q;

  assign ram_we    = cmd_i.clr_step || (cmd_i.resp_en && wr_q);
  assign ram_waddr = cmd_i.clr_step ? clr_cnt_q : set_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : row_q;

  satlb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(set_q),
    .rdata_o(ram_rdata)
  );

  // unpack the row that was read
  logic [WAYS-1:0]   v;
  logic [PW-1:0]     pg [WAYS];
  logic [PW-1:0]     fr [WAYS];
  logic [RANK_W-1:0] rk [WAYS];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      v[w]  = ram_rdata[w*WAY_W];
      pg[w] = ram_rdata[w*WAY_W+1 +: PW];
      fr[w] = ram_rdata[w*WAY_W+1+PW +: PW];
      rk[w] = ram_rdata[w*WAY_W+1+2*PW +: RANK_W];
    end
  end

  // way search: first match, first invalid, first of oldest rank
  logic              hit_any, inv_any;
  logic [WIDX_W-1:0] hit_way, inv_way, old_way, victim;
  logic [RANK_W-1:0] hit_rank;

  always_comb begin
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (v[w] && pg[w] == page_q) begin
        hit_any = 1'b1;
        hit_way = WIDX_W'(w);
      end
      if (!v[w]) begin
        inv_any = 1'b1;
        inv_way = WIDX_W'(w);
      end
      if (rk[w] == RANK_W'(WAYS)) begin
        old_way = WIDX_W'(w);
      end
    end
    victim   = inv_any ? inv_way : old_way;
    hit_rank = rk[hit_way];
  end

  // row update and result
  logic [WAYS-1:0]       nv;
  logic [PW-1:0]         npg [WAYS];
  logic [PW-1:0]         nfr [WAYS];
  logic [RANK_W-1:0]     nrk [WAYS];
  logic [ROW_W-1:0]      row_new;
  logic [ADDR_W-1:0]     res_pa;
  logic                  res_hit, res_fault, res_wr;
  logic [RANK_OUT_W-1:0] res_rank;
  logic [31:0]           rank_ext;

  always_comb begin
    nv        = v;
    npg       = pg;
    nfr       = fr;
    nrk       = rk;
    res_pa    = '0;
    res_hit   = 1'b0;
    res_fault = 1'b0;
    res_wr    = 1'b0;
    res_rank  = '0;
    rank_ext  = 32'(hit_rank);
    unique case (func_q)
      FUNC_XLATE: begin
        if (hit_any) begin
          // promote the hit way, age the more recent ones
          for (int w = 0; w < WAYS; w++) begin
            if (v[w] && rk[w] < hit_rank) begin
              nrk[w] = rk[w] + RANK_W'(1);
            end
          end
          nrk[hit_way] = RANK_W'(1);
          res_pa       = {fr[hit_way], off_q};
          res_hit      = 1'b1;
          res_wr       = 1'b1;
        end else if (walk_fault_q) begin
          res_pa    = '1;
          res_fault = 1'b1;
        end else begin
          // refill from the walk, age every other valid way not already oldest
          for (int w = 0; w < WAYS; w++) begin
            if (WIDX_W'(w) != victim && v[w] && rk[w] < RANK_W'(WAYS)) begin
              nrk[w] = rk[w] + RANK_W'(1);
            end
          end
          nv[victim]  = 1'b1;
          npg[victim] = page_q;
          nfr[victim] = walk_frame_q;
          nrk[victim] = RANK_W'(1);
          res_pa      = {walk_frame_q, off_q};
          res_wr      = 1'b1;
        end
      end
      FUNC_PEEK: begin
        if (hit_any) begin
          res_hit  = 1'b1;
          res_rank = rank_ext[RANK_OUT_W-1:0];
        end
      end
      FUNC_CLEAR, FUNC_RSVD: begin
        res_wr = 1'b0;
      end
      default: res_wr = 1'b0;
    endcase
    for (int w = 0; w < WAYS; w++) begin
      row_new[w*WAY_W +: WAY_W] = {nrk[w], nfr[w], npg[w], nv[w]};
    end
  end

  // lookup result register
  logic [ADDR_W-1:0]     res_pa_q;
  logic                  res_hit_q, res_fault_q;
  logic [RANK_OUT_W-1:0] res_rank_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_en) begin
      row_q       <= row_new;
      wr_q        <= res_wr;
      res_pa_q    <= res_pa;
      res_hit_q   <= res_hit;
      res_fault_q <= res_fault;
      res_rank_q  <= res_rank;
    end
  end

  // output register
  logic                  out_valid_q;
  logic [ADDR_W-1:0]     out_pa_q;
  logic                  out_hit_q, out_fault_q;
  logic [RANK_OUT_W-1:0] out_rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_en) begin
      out_pa_q    <= res_pa_q;
      out_hit_q   <= res_hit_q;
      out_fault_q <= res_fault_q;
      out_rank_q  <= res_rank_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_DATA_W'({out_rank_q, out_fault_q, out_hit_q, out_pa_q});

  // status back to the controller
  assign status_o.mod_done = (mod_cnt_q == '0);
  assign status_o.is_clear = (func_q == FUNC_CLEAR);
  assign status_o.clr_last = clr_last;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  // a result never claims both a hit and a walk fault
  a_hit_fault_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_hit_q && out_fault_q))
    else $error("result shows hit and fault together");

  // a nonzero rank is only reported for a matching way
  a_rank_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rank_q != '0) |-> out_hit_q)
    else $error("rank reported without a hit");

  // the row is never written back while the output slot is stalled
  a_wb_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.resp_en && wr_q) |-> !(out_valid_q && !out_ready_i))
    else $error("row write-back while result slot is stalled");
`endif

endmodule

### sv/set_assoc_tlb_lru.sv
// Set-associative TLB with true-LRU replacement, one transaction at a time.
// Each transaction computes its set index (by iterative modulo when SETS is not a
// power of two), reads the set row, registers the lookup and row update, then the result.
// A new transaction waits until the last one leaves DONE; a result not yet taken
// holds the next one, since the output register holds a single result.
// Reset, and every clear item, runs a sweep over all SETS rows that zeroes the table.
`timescale 1ns / 1ps

module set_assoc_tlb_lru import satlb_pkg::*; #(
  parameter int unsigned SETS      = SETS_DEF,
  parameter int unsigned WAYS      = WAYS_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // va [63:0], walk_pa [127:64], walk_fault [128], zero fill [135:129]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // func [1:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pa [63:0], hit [64], fault [65], rank [68:66], zero fill [71:69]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  satlb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // lookup, update and result path
  satlb_dp #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .PAGE_BITS(PAGE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .in_func_i  (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

### test/set_assoc_tlb_lru_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the set-associative tlb with lru replacement

module set_assoc_tlb_lru_test;
  import satlb_pkg::*;

  localparam int unsigned PAGE_W         = ADDR_W - PAGE_BITS_DEF;
  localparam logic [ADDR_W-1:0] OFF_MASK = (64'd1 << PAGE_BITS_DEF) - 64'd1;
  localparam int unsigned RANDOM_ITEMS   = 1950;
  localparam int unsigned QUIET_TAIL     = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned POOL_SIZE      = 32;
  localparam int unsigned SHOWN_ERRORS   = 10;

  // one lookup request and one lookup response, unpacked
  typedef struct {
    func_e             func;
    logic [ADDR_W-1:0] va;
    logic [ADDR_W-1:0] walk_pa;
    logic              walk_fault;
  } xlat_req_t;

  typedef struct {
    logic [ADDR_W-1:0]     pa;
    logic                  hit;
    logic                  fault;
    logic [RANK_OUT_W-1:0] rank;
  } xlat_resp_t;

  // shadow copy of the tlb table plus the queue of responses it predicts
  class tlb_mirror;
    bit                vld   [SETS_DEF][WAYS_DEF];
    logic [PAGE_W-1:0] page  [SETS_DEF][WAYS_DEF];
    logic [ADDR_W-1:0] frame [SETS_DEF][WAYS_DEF];
    int unsigned       lru   [SETS_DEF][WAYS_DEF];
    xlat_resp_t        expected_resp[$];
    int unsigned       mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      foreach (vld[s, w]) begin
        vld[s][w]   = 1'b0;
        page[s][w]  = '0;
        frame[s][w] = '0;
        lru[s][w]   = 0;
      end
    endfunction

    function int unsigned outstanding();
      return expected_resp.size();
    endfunction

    // apply one accepted request to the shadow table and queue its response
    function void take_request(xlat_req_t r);
      xlat_resp_t        rsp;
      logic [PAGE_W-1:0] pg;
      logic [ADDR_W-1:0] offset;
      int unsigned       set_idx;
      int unsigned       promo_rank;
      int                way;
      int                victim;
      int                w;
      rsp     = '{default: '0};
      pg      = r.va[ADDR_W-1:PAGE_BITS_DEF];
      offset  = r.va & OFF_MASK;
      set_idx = pg % SETS_DEF;
      way     = -1;
      for (w = 0; w < WAYS_DEF; w++) begin
        if (way < 0 && vld[set_idx][w] && page[set_idx][w] == pg) way = w;
      end
      case (r.func)
        FUNC_XLATE: begin
          if (way >= 0) begin
            // hit: promote to most recent, age the more recent ways
            promo_rank = lru[set_idx][way];
            for (w = 0; w < WAYS_DEF; w++) begin
              if (vld[set_idx][w] && lru[set_idx][w] < promo_rank) lru[set_idx][w]++;
            end
            lru[set_idx][way] = 1;
            rsp.pa  = frame[set_idx][way] | offset;
            rsp.hit = 1'b1;
          end else if (r.walk_fault) begin
            rsp.pa    = '1;
            rsp.fault = 1'b1;
          end else begin
            // miss: first free way, else the least recent one
            victim = -1;
            for (w = 0; w < WAYS_DEF; w++) begin
              if (victim < 0 && !vld[set_idx][w]) victim = w;
            end
            for (w = 0; w < WAYS_DEF; w++) begin
              if (victim < 0 && lru[set_idx][w] == WAYS_DEF) victim = w;
            end
            if (victim < 0) victim = 0;
            vld[set_idx][victim]   = 1'b1;
            page[set_idx][victim]  = pg;
            frame[set_idx][victim] = r.walk_pa & ~OFF_MASK;
            for (w = 0; w < WAYS_DEF; w++) begin
              if (w != victim && vld[set_idx][w] && lru[set_idx][w] < WAYS_DEF)
                lru[set_idx][w]++;
            end
            lru[set_idx][victim] = 1;
            rsp.pa = frame[set_idx][victim] | offset;
          end
        end
        FUNC_PEEK: begin
          if (way >= 0) begin
            rsp.hit  = 1'b1;
            rsp.rank = RANK_OUT_W'(lru[set_idx][way]);
          end
        end
        FUNC_CLEAR: wipe();
        default: ;
      endcase
      expected_resp.push_back(rsp);
    endfunction

    // compare one accepted response against the oldest prediction
    function void check_response(xlat_resp_t got);
      xlat_resp_t want;
      if (expected_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("unexpected response: pa=%h hit=%b fault=%b rank=%0d",
                   got.pa, got.hit, got.fault, got.rank);
        return;
      end
      want = expected_resp.pop_front();
      if (got.pa !== want.pa || got.hit !== want.hit ||
          got.fault !== want.fault || got.rank !== want.rank) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display(
            "mismatch: exp pa=%h hit=%b fault=%b rank=%0d, got pa=%h hit=%b fault=%b rank=%0d",
            want.pa, want.hit, want.fault, want.rank,
            got.pa, got.hit, got.fault, got.rank);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [FUNC_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  tlb_mirror         mirror = new();
  bit                src_idle_en = 1'b1;
  bit                snk_idle_en = 1'b1;
  int unsigned       quiet_cycles;
  logic [PAGE_W-1:0] page_pool [POOL_SIZE];

  always #10 clk_i = ~clk_i;

  set_assoc_tlb_lru i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // sample both sides at the rising edge
  always @(posedge clk_i) begin
    xlat_req_t  req;
    xlat_resp_t rsp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rsp.pa    = m_axis_tdata[ADDR_W-1:0];
      rsp.hit   = m_axis_tdata[ADDR_W];
      rsp.fault = m_axis_tdata[ADDR_W+1];
      rsp.rank  = m_axis_tdata[ADDR_W+2 +: RANK_OUT_W];
      mirror.check_response(rsp);
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      req.va         = s_axis_tdata[ADDR_W-1:0];
      req.walk_pa    = s_axis_tdata[2*ADDR_W-1:ADDR_W];
      req.walk_fault = s_axis_tdata[2*ADDR_W];
      req.func       = func_e'(s_axis_tuser);
      mirror.take_request(req);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("set_assoc_tlb_lru_test: FAIL");
    $finish;
  end

  // response side backpressure in random bursts
  initial begin
    int unsigned span;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        span = $urandom_range(1, 4);
      end else begin
        m_axis_tready <= 1'b1;
        span = $urandom_range(1, 6);
      end
      repeat (span - 1) @(negedge clk_i);
    end
  end

  function automatic xlat_req_t mk_req(func_e f, logic [ADDR_W-1:0] va,
                                       logic [ADDR_W-1:0] walk_pa, logic walk_fault);
    xlat_req_t r;
    r.func       = f;
    r.va         = va;
    r.walk_pa    = walk_pa;
    r.walk_fault = walk_fault;
    return r;
  endfunction

  // drive one request from a falling edge until it is taken
  task automatic send_req(input xlat_req_t r);
    logic [IN_DATA_W-1:0] word;
    int unsigned          gap;
    word = '0;
    word[ADDR_W-1:0]        = r.va;
    word[2*ADDR_W-1:ADDR_W] = r.walk_pa;
    word[2*ADDR_W]          = r.walk_fault;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= r.func;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  initial begin
    logic [ADDR_W-1:0] r64;
    logic [ADDR_W-1:0] va;
    func_e             f;
    int unsigned       roll;
    int unsigned       i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_XLATE;

    // pages crowded into a few sets so that evictions happen often
    for (i = 0; i < POOL_SIZE; i++) begin
      r64 = {$urandom, $urandom};
      page_pool[i] = {r64[PAGE_W-1:4], 4'($urandom_range(0, 5))};
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, fill, fault, eviction, reserved code, clear
    send_req(mk_req(FUNC_PEEK,  64'h0, 64'h0, 1'b0));
    send_req(mk_req(FUNC_XLATE, 64'h0, '1, 1'b0));
    send_req(mk_req(FUNC_XLATE, 64'h0abc, 64'h0, 1'b1));
    send_req(mk_req(FUNC_XLATE, '1, '1, 1'b1));
    send_req(mk_req(FUNC_XLATE, '1, 64'h0, 1'b0));
    send_req(mk_req(FUNC_PEEK,  '1, 64'h0, 1'b0));
    send_req(mk_req(FUNC_XLATE, 64'h10123, {$urandom, $urandom}, 1'b0));
    send_req(mk_req(FUNC_XLATE, 64'h20fff, {$urandom, $urandom}, 1'b0));
    send_req(mk_req(FUNC_XLATE, 64'h30000, {$urandom, $urandom}, 1'b0));
    send_req(mk_req(FUNC_PEEK,  64'h0, 64'h0, 1'b0));
    send_req(mk_req(FUNC_XLATE, 64'h20555, '1, 1'b1));
    send_req(mk_req(FUNC_XLATE, 64'h40001, {$urandom, $urandom}, 1'b0));
    send_req(mk_req(FUNC_PEEK,  64'h0, 64'h0, 1'b0));
    send_req(mk_req(FUNC_PEEK,  64'h10000, 64'h0, 1'b0));
    send_req(mk_req(FUNC_PEEK,  64'h40fff, '1, 1'b1));
    send_req(mk_req(FUNC_RSVD,  '1, '1, 1'b1));
    send_req(mk_req(FUNC_PEEK,  '1, 64'h0, 1'b0));
    send_req(mk_req(FUNC_CLEAR, '1, '1, 1'b1));
    send_req(mk_req(FUNC_PEEK,  64'h20000, 64'h0, 1'b0));
    send_req(mk_req(FUNC_XLATE, 64'h20000, {$urandom, $urandom}, 1'b0));
    send_req(mk_req(FUNC_PEEK,  64'h20000, 64'h0, 1'b0));

    // random traffic mostly on pooled pages so that hits and evictions are common
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_TAIL) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end
      // hold off once until the block has drained
      if (i == RANDOM_ITEMS / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (mirror.outstanding() != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 72)      f = FUNC_XLATE;
      else if (roll < 95) f = FUNC_PEEK;
      else if (roll < 99) f = FUNC_RSVD;
      else                f = FUNC_CLEAR;
      if ($urandom_range(0, 99) < 85)
        va = {page_pool[$urandom_range(0, POOL_SIZE - 1)], 12'($urandom)};
      else
        va = {$urandom, $urandom};
      send_req(mk_req(f, va, {$urandom, $urandom}, $urandom_range(0, 9) == 0));
    end
    s_axis_tvalid <= 1'b0;

    // let every predicted response arrive, then watch for strays
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.outstanding() == 0)
      $display("set_assoc_tlb_lru_test: PASS");
    else
      $display("set_assoc_tlb_lru_test: FAIL");
    $finish;
  end

endmodule
